// ===== rtl/core/cfr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cfr_pkg;

  // Frame kinds as reported on the result channel
  typedef enum logic [1:0] {
    KIND_CXN = 2'd0,
    KIND_CNF = 2'd1,
    KIND_CNT = 2'd2,
    KIND_DCX = 2'd3
  } kind_t;

  // Header characters (ASCII)
  localparam logic [7:0] CH_C = 8'h43;
  localparam logic [7:0] CH_D = 8'h44;
  localparam logic [7:0] CH_F = 8'h46;
  localparam logic [7:0] CH_N = 8'h4E;
  localparam logic [7:0] CH_T = 8'h54;
  localparam logic [7:0] CH_X = 8'h58;

  // Payload lengths, address byte included
  localparam logic [2:0] LEN_CNF   = 3'd4;
  localparam logic [2:0] LEN_CNT   = 3'd3;
  localparam logic [2:0] LEN_SHORT = 3'd1;

  // One result beat
  typedef struct packed {
    kind_t       frame_kind;
    logic        link_up;
    logic [7:0]  peer_address;
    logic [7:0]  speed_setpoint;
    logic [7:0]  emergency_stop;
    logic [7:0]  accel_setpoint;
    logic [15:0] cable_length;
    logic        setpoint_changed;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/command_frame_receiver_top.sv =====
// Takes one byte per cycle; in_stall rises only while both the output
// register and the skid register hold results that have not been taken.
// The result of a frame goes from the parser straight into the output
// register, or into the skid register while out_stall holds the output back.
// Reset (rst, synchronous) clears the parser, the link state, the setpoints
// and the valid flags of both result registers; the block takes bytes the cycle after.
`timescale 1ns / 1ps
`default_nettype none

module command_frame_receiver_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       frame_kind,
  output logic             link_up,
  output logic [7:0]       peer_address,
  output logic [7:0]       speed_setpoint,
  output logic [7:0]       emergency_stop,
  output logic [7:0]       accel_setpoint,
  output logic [15:0]      cable_length,
  output logic             setpoint_changed
);
  import cfr_pkg::*;

  logic    beat;
  logic    res_valid;
  result_t res;
  result_t out_q;
  result_t skid_q;
  logic    skid_valid;

  assign in_stall = skid_valid;
  assign beat     = in_valid && !skid_valid;

  cfr_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .beat      (beat),
    .rx_byte   (rx_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  // Output register with one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !out_stall) begin
      if (skid_valid) begin
        out_q      <= skid_q;
        skid_valid <= 1'b0;
      end else if (res_valid) begin
        out_q <= res;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (!out_valid) begin
      if (res_valid) begin
        out_q     <= res;
        out_valid <= 1'b1;
      end
    end else if (res_valid) begin
      skid_q     <= res;
      skid_valid <= 1'b1;
    end
  end

  assign frame_kind       = out_q.frame_kind;
  assign link_up          = out_q.link_up;
  assign peer_address     = out_q.peer_address;
  assign speed_setpoint   = out_q.speed_setpoint;
  assign emergency_stop   = out_q.emergency_stop;
  assign accel_setpoint   = out_q.accel_setpoint;
  assign cable_length     = out_q.cable_length;
  assign setpoint_changed = out_q.setpoint_changed;

endmodule

`default_nettype wire

// ===== rtl/core/cfr_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cfr_parser (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            beat,
  input  wire logic [7:0]      rx_byte,
  output logic                 res_valid,
  output cfr_pkg::result_t     res
);
  import cfr_pkg::*;

  localparam logic [2:0] PH_HDR0    = 3'd0;
  localparam logic [2:0] PH_HDR1    = 3'd1;
  localparam logic [2:0] PH_HDR2    = 3'd2;
  localparam logic [2:0] PH_PAYLOAD = 3'd3;

  // Parser and link state
  logic [2:0]  phase, phase_next;
  kind_t       kind_seen, kind_seen_next;
  logic [7:0]  sum, sum_next;
  logic [7:0]  payload [4];
  logic [7:0]  payload_next [4];
  logic        mode_conn, mode_conn_next;
  logic        connected, connected_next;
  logic [7:0]  address, address_next;
  logic [7:0]  speed, speed_next;
  logic [7:0]  stop, stop_next;
  logic [7:0]  accel, accel_next;
  logic [15:0] length, length_next;
  logic [31:0] reported, reported_next;

  logic [2:0]  k;
  logic [2:0]  plen;
  logic        emit;
  logic        addr_ok;
  logic [31:0] now;

  assign k       = phase - PH_PAYLOAD;
  assign addr_ok = (payload[0] == address);

  always_comb begin
    unique case (kind_seen)
      KIND_CNF: plen = LEN_CNF;
      KIND_CNT: plen = LEN_CNT;
      default:  plen = LEN_SHORT;
    endcase
  end

  // Per-beat state transition
  always_comb begin
    phase_next     = phase;
    kind_seen_next = kind_seen;
    sum_next       = sum;
    payload_next   = payload;
    mode_conn_next = mode_conn;
    connected_next = connected;
    address_next   = address;
    speed_next     = speed;
    stop_next      = stop;
    accel_next     = accel;
    length_next    = length;
    emit           = 1'b0;
    if (beat) begin
      priority case (phase)
        PH_HDR0: begin
          mode_conn_next = connected;
          if (connected ? (rx_byte == CH_C || rx_byte == CH_D) : (rx_byte == CH_C)) begin
            payload_next[0] = rx_byte;
            sum_next        = rx_byte;
            phase_next      = PH_HDR1;
          end else begin
            phase_next = PH_HDR0;
            sum_next   = 8'd0;
          end
        end
        PH_HDR1: begin
          if (mode_conn ? (rx_byte == CH_N || rx_byte == CH_C) : (rx_byte == CH_X)) begin
            payload_next[1] = rx_byte;
            sum_next        = sum + rx_byte;
            phase_next      = PH_HDR2;
          end else begin
            phase_next = PH_HDR0;
            sum_next   = 8'd0;
          end
        end
        PH_HDR2: begin
          phase_next = PH_PAYLOAD;
          sum_next   = sum + rx_byte;
          if (!mode_conn) begin
            if (payload[0] == CH_C && payload[1] == CH_X && rx_byte == CH_N) begin
              kind_seen_next = KIND_CXN;
            end else begin
              phase_next = PH_HDR0;
              sum_next   = 8'd0;
            end
          end else if (payload[0] == CH_C && payload[1] == CH_N && rx_byte == CH_F) begin
            kind_seen_next = KIND_CNF;
          end else if (payload[0] == CH_C && payload[1] == CH_N && rx_byte == CH_T) begin
            kind_seen_next = KIND_CNT;
          end else if (payload[0] == CH_D && payload[1] == CH_C && rx_byte == CH_X) begin
            kind_seen_next = KIND_DCX;
          end else begin
            phase_next = PH_HDR0;
            sum_next   = 8'd0;
          end
        end
        default: begin
          if (k < plen) begin
            // payload byte
            payload_next[k[1:0]] = rx_byte;
            sum_next             = sum + rx_byte;
            phase_next           = phase + 3'd1;
          end else begin
            // checksum byte closes the frame
            phase_next = PH_HDR0;
            sum_next   = 8'd0;
            if (rx_byte == sum) begin
              unique case (kind_seen)
                KIND_CXN: begin
                  emit           = 1'b1;
                  connected_next = 1'b1;
                  address_next   = payload[0];
                end
                KIND_CNF: begin
                  emit = addr_ok;
                  if (addr_ok) begin
                    accel_next  = payload[1];
                    length_next = {payload[2], payload[3]};
                  end
                end
                KIND_CNT: begin
                  emit = addr_ok;
                  if (addr_ok) begin
                    speed_next = payload[1];
                    stop_next  = payload[2];
                  end
                end
                KIND_DCX: begin
                  emit = 1'b1;
                  if (addr_ok) begin
                    connected_next = 1'b0;
                    address_next   = 8'd0;
                  end
                end
              endcase
            end
          end
        end
      endcase
    end
  end

  // Result built from the updated state
  assign now           = {speed_next, accel_next, length_next};
  assign reported_next = emit ? now : reported;

  always_comb begin
    res.frame_kind       = kind_seen;
    res.link_up          = connected_next;
    res.peer_address     = address_next;
    res.speed_setpoint   = speed_next;
    res.emergency_stop   = stop_next;
    res.accel_setpoint   = accel_next;
    res.cable_length     = length_next;
    res.setpoint_changed = (now != reported);
  end
  assign res_valid = emit;

  always_ff @(posedge clk) begin
    payload <= payload_next;
    if (rst) begin
      phase     <= PH_HDR0;
      kind_seen <= KIND_CXN;
      sum       <= 8'd0;
      mode_conn <= 1'b0;
      connected <= 1'b0;
      address   <= 8'd0;
      speed     <= 8'd0;
      stop      <= 8'd0;
      accel     <= 8'd0;
      length    <= 16'd0;
      reported  <= 32'd0;
    end else begin
      phase     <= phase_next;
      kind_seen <= kind_seen_next;
      sum       <= sum_next;
      mode_conn <= mode_conn_next;
      connected <= connected_next;
      address   <= address_next;
      speed     <= speed_next;
      stop      <= stop_next;
      accel     <= accel_next;
      length    <= length_next;
      reported  <= reported_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/cfr_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cfr_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [1:0]  frame_kind,
  input wire logic        link_up,
  input wire logic [7:0]  peer_address,
  input wire logic [15:0] cable_length
);
  import cfr_pkg::*;

  // A stalled result beat stays valid
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped under stall");

  // A stalled result beat keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(peer_address) && $stable(cable_length)
                               && $stable(frame_kind))
    else $error("result payload changed under stall");

  // A link that is down never carries an address
  a_down_no_addr: assert property (@(posedge clk) disable iff (rst)
    out_valid && !link_up |-> peer_address == 8'd0)
    else $error("address kept while link is down");

  // Connect, config and control results only come with the link up
  a_kind_link: assert property (@(posedge clk) disable iff (rst)
    out_valid && (frame_kind == KIND_CXN || frame_kind == KIND_CNF ||
                  frame_kind == KIND_CNT) |-> link_up)
    else $error("frame accepted while link is down");

endmodule

bind command_frame_receiver_top cfr_checker u_cfr_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .frame_kind   (frame_kind),
  .link_up      (link_up),
  .peer_address (peer_address),
  .cable_length (cable_length)
);

`default_nettype wire
